// File: rtl/core/mrt_pkg.sv
// Shared types and constants for the masked rule table state machine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mrt_pkg;

  localparam int STATE_W     = 3;
  localparam int MASK_W      = 32;
  localparam int CNT_W       = 3;
  localparam int ACT_W       = 3;
  localparam int MAX_ACTIONS = 4;
  localparam int ACTS_W      = 12;
  localparam int INDEX_W     = 6;
  localparam int EMIT_W      = $clog2(MAX_ACTIONS);

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_STEP = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } fsm_e;

  typedef struct packed {
    logic               valid;
    logic [STATE_W-1:0] state;
    logic [STATE_W-1:0] next;
    logic [CNT_W-1:0]   cnt;
    logic [ACTS_W-1:0]  acts;
    logic [MASK_W-1:0]  req;
    logic [MASK_W-1:0]  forb;
  } mrt_rule_t;

  typedef struct packed {
    logic               en;
    logic [INDEX_W-1:0] idx;
    mrt_rule_t          rule;
  } mrt_wr_t;

  typedef struct packed {
    logic               hit;
    logic [STATE_W-1:0] next;
    logic [CNT_W-1:0]   cnt;
    logic [ACTS_W-1:0]  acts;
  } mrt_hit_t;

endpackage

// File: rtl/core/mrt_rule_mem.sv
// Rule storage: mask and control memories with one registered read port.
// Depends on mrt_pkg.
`timescale 1ns / 1ps

module mrt_rule_mem
  import mrt_pkg::*;
#(
  parameter int RULE_COUNT = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mrt_wr_t                       wr_i,
  input  logic [$clog2(RULE_COUNT)-1:0] rd_addr_i,
  output mrt_rule_t                     rd_data_o
);

  localparam int IdxW = $clog2(RULE_COUNT);
  localparam int CtlW = 2 * STATE_W + CNT_W + ACTS_W;

  logic [2*MASK_W-1:0]   mask_mem [RULE_COUNT];
  logic [CtlW-1:0]       ctrl_mem [RULE_COUNT];
  logic [RULE_COUNT-1:0] valid_q;
  logic [IdxW-1:0]       wr_addr;
  logic [2*MASK_W-1:0]   rd_mask_q;
  logic [CtlW-1:0]       rd_ctrl_q;
  logic                  rd_valid_q;

  assign wr_addr = IdxW'(wr_i.idx);

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mask_mem[wr_addr] <= {wr_i.rule.forb, wr_i.rule.req};
      ctrl_mem[wr_addr] <= {wr_i.rule.state, wr_i.rule.next, wr_i.rule.cnt, wr_i.rule.acts};
    end
    rd_mask_q <= mask_mem[rd_addr_i];
    rd_ctrl_q <= ctrl_mem[rd_addr_i];
  end

  // Valid bits live in flops so reset clears the whole table at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_addr] <= wr_i.rule.valid;
      end
      rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  always_comb begin
    rd_data_o.valid = rd_valid_q;
    {rd_data_o.state, rd_data_o.next, rd_data_o.cnt, rd_data_o.acts} = rd_ctrl_q;
    {rd_data_o.forb, rd_data_o.req} = rd_mask_q;
  end

endmodule

// File: rtl/core/mrt_match.sv
// Rule match check against current state and vision mask; saturates action count.
// Depends on mrt_pkg.
`timescale 1ns / 1ps

module mrt_match
  import mrt_pkg::*;
(
  input  mrt_rule_t          rule_i,
  input  logic [STATE_W-1:0] cur_state_i,
  input  logic [MASK_W-1:0]  vision_i,
  output mrt_hit_t           hit_o
);

  logic fits;

  always_comb begin
    fits       = ((rule_i.forb & vision_i) == '0) && ((rule_i.req & ~vision_i) == '0);
    hit_o.hit  = rule_i.valid && (rule_i.state == cur_state_i) && fits;
    hit_o.next = rule_i.next;
    hit_o.acts = rule_i.acts;
    // clamp the loaded count to the action slots we have
    hit_o.cnt  = (rule_i.cnt > CNT_W'(MAX_ACTIONS)) ? CNT_W'(MAX_ACTIONS) : rule_i.cnt;
  end

endmodule

// File: rtl/core/masked_rule_table_fsm.sv
// Top level of the programmable rule table state machine.
// Depends on mrt_pkg, mrt_rule_mem and mrt_match.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid_i / in_stall_o) carries load and step transactions.
//   A load transaction (kind 0) writes one rule slot and gives no
//   result; slots at or beyond RULE_COUNT are dropped. A step transaction
//   (kind 1) scans the table from slot 0, one slot per cycle through the rule
//   memory read port, and stops at the first matching rule.
//   A hit emits one result per action (at least one); a step that matches
//   nothing shows a single result. The input stalls from the acceptance of a
//   step until its final result is loaded, so a new step or load waits for
//   the current step; a load never stalls the input.
//   The next transaction is taken as soon as the final result of a step sits
//   in the output register, even while the receiver still holds it.
//   Output channel (out_valid_o / out_stall_i): while out_stall_i is high with a
//   result pending, the result register holds and action emission waits.
//   Reset clears all rule valid bits, the current state (to 0) and both
//   channels; rule masks stay undefined until loaded.
module masked_rule_table_fsm
  import mrt_pkg::*;
#(
  parameter int RULE_COUNT = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [0:0]           kind_i,
  input  logic [INDEX_W-1:0]   rule_index_i,
  input  logic [0:0]           rule_valid_i,
  input  logic [STATE_W-1:0]   rule_state_i,
  input  logic [STATE_W-1:0]   rule_next_state_i,
  input  logic [MASK_W-1:0]    required_bits_i,
  input  logic [MASK_W-1:0]    forbidden_bits_i,
  input  logic [CNT_W-1:0]     action_count_i,
  input  logic [ACTS_W-1:0]    actions_packed_i,
  input  logic [MASK_W-1:0]    vision_mask_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [0:0]           matched_o,
  output logic [0:0]           action_valid_o,
  output logic [ACT_W-1:0]     action_o,
  output logic [STATE_W-1:0]   new_state_o,
  output logic [0:0]           last_o
);

  localparam int IdxW = $clog2(RULE_COUNT);
  localparam int CmpW = INDEX_W + 3;

  fsm_e state_q, state_d;

  logic [IdxW-1:0]    scan_idx_q, scan_idx_d;
  logic               issue_on_q, issue_on_d;
  logic               rd_vld_q, rd_vld_d;
  logic               rd_last_q, rd_last_d;
  logic [MASK_W-1:0]  vision_q;
  logic [STATE_W-1:0] cur_state_q, cur_state_d;
  logic               hit_q;
  logic [STATE_W-1:0] ns_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [ACTS_W-1:0]  acts_q;
  logic [EMIT_W-1:0]  emit_idx_q, emit_idx_d;

  logic               out_valid_q, out_valid_d;
  logic               res_matched_q, res_av_q, res_last_q;
  logic [ACT_W-1:0]   res_act_q;
  logic [STATE_W-1:0] res_ns_q;

  logic               in_acc, is_step, issue, hit_now, miss_end, capture;
  logic               out_load, res_last, res_av;
  logic [ACT_W-1:0]   res_act;
  mrt_wr_t            wr;
  mrt_rule_t          rd_rule;
  mrt_hit_t           match;

  // ---------------------------------------------------------------------------
  // Rule storage; loads never overlap a scan, so no forwarding is needed.
  // ---------------------------------------------------------------------------
  always_comb begin
    wr.en         = in_acc && (kind_e'(kind_i) == KIND_LOAD)
                    && ({3'b000, rule_index_i} < CmpW'(RULE_COUNT));
    wr.idx        = rule_index_i;
    wr.rule.valid = rule_valid_i[0];
    wr.rule.state = rule_state_i;
    wr.rule.next  = rule_next_state_i;
    wr.rule.cnt   = action_count_i;
    wr.rule.acts  = actions_packed_i;
    wr.rule.req   = required_bits_i;
    wr.rule.forb  = forbidden_bits_i;
  end

  mrt_rule_mem #(
    .RULE_COUNT(RULE_COUNT)
  ) u_rule_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr),
    .rd_addr_i(scan_idx_q),
    .rd_data_o(rd_rule)
  );

  mrt_match u_match (
    .rule_i     (rd_rule),
    .cur_state_i(cur_state_q),
    .vision_i   (vision_q),
    .hit_o      (match)
  );

  // ---------------------------------------------------------------------------
  // Control decode
  // ---------------------------------------------------------------------------
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    in_acc     = in_valid_i && !in_stall_o;
    is_step    = in_acc && (kind_e'(kind_i) == KIND_STEP);
    issue      = (state_q == ST_SCAN) && issue_on_q;
    hit_now    = (state_q == ST_SCAN) && rd_vld_q && match.hit;
    miss_end   = (state_q == ST_SCAN) && rd_vld_q && !match.hit && rd_last_q;
    capture    = hit_now || miss_end;
    out_load   = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
    res_last   = (cnt_q == '0) || ((CNT_W'(emit_idx_q) + CNT_W'(1)) == cnt_q);
    res_av     = hit_q && (cnt_q != '0);
    res_act    = res_av ? acts_q[emit_idx_q*ACT_W +: ACT_W] : '0;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (is_step)              state_d = ST_SCAN;
      ST_SCAN: if (capture)              state_d = ST_EMIT;
      ST_EMIT: if (out_load && res_last) state_d = ST_IDLE;
      default:                           state_d = ST_IDLE;
    endcase
  end

  // Counters and scan bookkeeping
  always_comb begin
    scan_idx_d  = scan_idx_q;
    issue_on_d  = issue_on_q;
    rd_vld_d    = issue && !hit_now;
    rd_last_d   = (scan_idx_q == IdxW'(RULE_COUNT - 1));
    cur_state_d = cur_state_q;
    emit_idx_d  = emit_idx_q;
    out_valid_d = out_valid_q;

    if (is_step) begin
      scan_idx_d = '0;
      issue_on_d = 1'b1;
    end else if (issue) begin
      // advance one slot per cycle; stop issuing after the last slot
      if (scan_idx_q == IdxW'(RULE_COUNT - 1)) begin
        issue_on_d = 1'b0;
      end else begin
        scan_idx_d = scan_idx_q + IdxW'(1);
      end
    end
    if (hit_now) begin
      issue_on_d  = 1'b0;
      cur_state_d = match.next;
    end

    if (capture) begin
      emit_idx_d = '0;
    end else if (out_load) begin
      emit_idx_d = emit_idx_q + EMIT_W'(1);
    end

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_idx_q  <= '0;
      issue_on_q  <= 1'b0;
      rd_vld_q    <= 1'b0;
      rd_last_q   <= 1'b0;
      cur_state_q <= '0;
      emit_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_idx_q  <= scan_idx_d;
      issue_on_q  <= issue_on_d;
      rd_vld_q    <= rd_vld_d;
      rd_last_q   <= rd_last_d;
      cur_state_q <= cur_state_d;
      emit_idx_q  <= emit_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: step context, captured rule and the result register
  always_ff @(posedge clk_i) begin
    if (is_step) begin
      vision_q <= vision_mask_i;
    end
    if (hit_now) begin
      hit_q  <= 1'b1;
      ns_q   <= match.next;
      cnt_q  <= match.cnt;
      acts_q <= match.acts;
    end else if (miss_end) begin
      // no rule fired: keep the state, emit one unmatched result
      hit_q  <= 1'b0;
      ns_q   <= cur_state_q;
      cnt_q  <= '0;
      acts_q <= '0;
    end
    if (out_load) begin
      res_matched_q <= hit_q;
      res_av_q      <= res_av;
      res_act_q     <= res_act;
      res_ns_q      <= ns_q;
      res_last_q    <= res_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign matched_o      = res_matched_q;
  assign action_valid_o = res_av_q;
  assign action_o       = res_act_q;
  assign new_state_o    = res_ns_q;
  assign last_o         = res_last_q;

`ifndef SYNTHESIS
  // A read in flight only exists while scanning.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == ST_SCAN))
    else $error("rule read pending outside scan");

  // Only a matched rule with actions can produce a non-final result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o[0]) |-> (matched_o[0] && action_valid_o[0]))
    else $error("non-final result without an action");

  // An unmatched step gives exactly one empty, final result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !matched_o[0]) |-> (!action_valid_o[0] && last_o[0]))
    else $error("malformed unmatched result");

  // Results are produced only from the emit state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |-> ($past(state_q) == ST_EMIT))
    else $error("result appeared outside emission");
`endif

endmodule
